// File: rtl/amcma_pkg.sv
// ----------------------------------------------------------------------------
// amcma_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the multichannel min-hold moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package amcma_pkg;

  // Block geometry
  localparam int CHANNELS      = 5;
  localparam int CAPTURES      = 4;
  localparam int HISTORY_DEPTH = 4;

  localparam int ROUND_SAMPLES = CHANNELS * CAPTURES;
  localparam int MEM_DEPTH     = CHANNELS * HISTORY_DEPTH;

  // Field and counter widths
  localparam int SAMPLE_W = 10;
  localparam int CH_W     = 3;
  localparam int CAP_W    = (ROUND_SAMPLES > 1) ? $clog2(ROUND_SAMPLES) : 1;
  localparam int HIST_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W    = SAMPLE_W + HIST_W;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'h3FF;

  // Input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_UPD,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic fill_wr;
    logic rd_sample;
    logic upd_sample;
    logic rd_sum;
    logic acc_sum;
    logic next_ch;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_is_sample;
    logic fill_last;
    logic round_end;
    logic sum_last;
    logic ch_last;
    logic out_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/amcma_ctrl.sv
// ----------------------------------------------------------------------------
// amcma_ctrl
// Sequencer for start fills, sample min-hold updates and the end-of-round
// averaging walk over the history store.
// ----------------------------------------------------------------------------
`default_nettype none

module amcma_ctrl
  import amcma_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd_o
);

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd_o      = '0;
    unique case (state)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = status.in_is_sample ? ST_RD : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_sample = 1'b1;
        state_next      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd_sample = 1'b1;
        state_next       = status.round_end ? ST_SUM_RD : ST_IDLE;
      end
      ST_SUM_RD: begin
        cmd_o.rd_sum = 1'b1;
        state_next   = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd_o.acc_sum = 1'b1;
        state_next    = status.sum_last ? ST_EMIT : ST_SUM_RD;
      end
      ST_EMIT: begin
        if (status.out_done) begin
          cmd_o.next_ch = 1'b1;
          state_next    = status.ch_last ? ST_IDLE : ST_SUM_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/amcma_dp.sv
// ----------------------------------------------------------------------------
// amcma_dp
// History store with per-entry valid bits, round counters, sum accumulator
// and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module amcma_dp
  import amcma_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_status_t               status,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cmd,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CH_W-1:0]          channel,
  output logic [SAMPLE_W-1:0]      average,
  output logic                     last
);

  // History store and its valid bits
  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_bits;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_hit;

  // Counters and working registers
  logic [CH_W-1:0]     channel_counter;
  logic [CAP_W-1:0]    capture_counter;
  logic [HIST_W-1:0]   history_index;
  logic [CH_W-1:0]     fill_ch;
  logic [CH_W-1:0]     avg_ch;
  logic [HIST_W-1:0]   avg_h;
  logic [SUM_W-1:0]    acc;
  logic [SAMPLE_W-1:0] sample_q;

  logic                in_xfer;
  logic                out_xfer;
  logic [SAMPLE_W-1:0] entry;
  logic [SUM_W-1:0]    sum_total;
  logic [ADDR_W-1:0]   sample_addr;
  logic [ADDR_W-1:0]   fill_addr;
  logic [ADDR_W-1:0]   sum_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                ch_wrap;
  logic                round_wrap;
  logic                hist_wrap;

  assign in_stall = !cmd_i.in_ready;
  assign in_xfer  = in_valid && cmd_i.in_ready;
  assign out_xfer = out_valid && !out_stall;

  // Form store addresses: slot-major, one row of channels per slot
  assign sample_addr = ADDR_W'(32'(history_index) * CHANNELS + 32'(channel_counter));
  assign fill_addr   = ADDR_W'(32'(history_index) * CHANNELS + 32'(fill_ch));
  assign sum_addr    = ADDR_W'(32'(avg_h) * CHANNELS + 32'(avg_ch));
  assign rd_addr     = cmd_i.rd_sum ? sum_addr : sample_addr;

  // An entry never written reads as zero
  assign entry     = rd_hit ? rd_data : '0;
  assign sum_total = acc + SUM_W'(entry);

  assign ch_wrap    = (channel_counter == CH_W'(CHANNELS - 1));
  assign round_wrap = (capture_counter == CAP_W'(ROUND_SAMPLES - 1));
  assign hist_wrap  = (history_index == HIST_W'(HISTORY_DEPTH - 1));

  // Select the single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_addr;
    wr_data = FULL_SCALE;
    if (cmd_i.fill_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.upd_sample && (sample_q < entry)) begin
      wr_en   = 1'b1;
      wr_addr = sample_addr;
      wr_data = sample_q;
    end
  end

  // Write and read the store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_sample || cmd_i.rd_sum) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_hit     <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_sample || cmd_i.rd_sum) begin
        rd_hit <= valid_bits[rd_addr];
      end
    end
  end

  // Capture the input sample on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_q <= sample;
    end
  end

  // Advance round counters and the fill pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter <= '0;
      capture_counter <= '0;
      history_index   <= '0;
      fill_ch         <= '0;
    end else begin
      if (cmd_i.fill_wr) begin
        fill_ch <= (fill_ch == CH_W'(CHANNELS - 1)) ? '0 : fill_ch + 1'b1;
      end
      if (cmd_i.upd_sample) begin
        channel_counter <= ch_wrap ? '0 : channel_counter + 1'b1;
        capture_counter <= round_wrap ? '0 : capture_counter + 1'b1;
        if (round_wrap) begin
          history_index <= hist_wrap ? '0 : history_index + 1'b1;
        end
      end
    end
  end

  // Walk channels and slots, accumulate the per-channel sum
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_ch <= '0;
      avg_h  <= '0;
      acc    <= '0;
    end else begin
      if (cmd_i.upd_sample && round_wrap) begin
        avg_ch <= '0;
        avg_h  <= '0;
        acc    <= '0;
      end
      if (cmd_i.acc_sum && !status.sum_last) begin
        acc   <= sum_total;
        avg_h <= avg_h + 1'b1;
      end
      if (cmd_i.next_ch) begin
        avg_ch <= avg_ch + 1'b1;
        avg_h  <= '0;
        acc    <= '0;
      end
    end
  end

  // Load the result register; drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.acc_sum && status.sum_last) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.acc_sum && status.sum_last) begin
      channel <= avg_ch;
      // HISTORY_DEPTH is a power of two, so this is a shift
      average <= SAMPLE_W'(sum_total / HISTORY_DEPTH);
      last    <= (avg_ch == CH_W'(CHANNELS - 1));
    end
  end

  // Report status
  always_comb begin
    status.in_valid     = in_valid;
    status.in_is_sample = (cmd == CMD_SAMPLE);
    status.fill_last    = (fill_ch == CH_W'(CHANNELS - 1));
    status.round_end    = round_wrap;
    status.sum_last     = (avg_h == HIST_W'(HISTORY_DEPTH - 1));
    status.ch_last      = (avg_ch == CH_W'(CHANNELS - 1));
    status.out_done     = out_xfer;
  end

endmodule

`default_nettype wire

// File: rtl/adc_min_capture_moving_average_top.sv
// A start transfer is accepted, then the fill writes the store once per channel.
// A sample transfer steps through accept, registered store read, min-hold write.
// Round end walks each channel with HISTORY_DEPTH store reads and accumulates for the sums,
// then hands off one result per channel; the single store read port serializes the reads.
// Reset: synchronous, active high; counters clear and per-entry valid bits make
// the history store read as zero until written.
// ----------------------------------------------------------------------------
// adc_min_capture_moving_average_top
// Multichannel min-hold capture with a moving average over the history slots.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_min_capture_moving_average_top
  import amcma_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cmd,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CH_W-1:0]          channel,
  output logic [SAMPLE_W-1:0]      average,
  output logic                     last
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Sequence the work
  amcma_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (dp_status),
    .cmd_o  (ctrl_cmd)
  );

  // Store, count and average
  amcma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_i     (ctrl_cmd),
    .status    (dp_status),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .average   (average),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: rtl/amcma_checker.sv
// ----------------------------------------------------------------------------
// amcma_checker
// Port-level checks on the result stream and input stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module amcma_checker
  import amcma_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [CH_W-1:0]     channel,
  input wire logic [SAMPLE_W-1:0] average,
  input wire logic                last
);

  // Hold a stalled result and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(channel) && $stable(average) && $stable(last))
    else $error("result dropped or changed while stalled");

  // Take no input while a result is pending
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // Keep working after a non-final result transfer
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> in_stall)
    else $error("round ended before the final channel");

  // Flag the final channel only
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel == CH_W'(CHANNELS - 1))))
    else $error("last flag does not match channel");

endmodule

bind adc_min_capture_moving_average_top amcma_checker u_amcma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .channel   (channel),
  .average   (average),
  .last      (last)
);

`default_nettype wire
